[sv/gwm_pkg.sv]
// shared constants, command codes and datapath command types for the glob wildcard matcher
package gwm_pkg;

  localparam int MASK_MAX = 64;
  localparam int LEN_W    = $clog2(MASK_MAX + 1);
  localparam int IDX_W    = $clog2(MASK_MAX);
  localparam int CHAR_W   = 16;

  localparam logic [CHAR_W-1:0] CH_STAR     = 16'd42;
  localparam logic [CHAR_W-1:0] CH_QMARK    = 16'd63;
  localparam logic [CHAR_W-1:0] CH_LOWER_A  = 16'd97;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z  = 16'd122;
  localparam logic [CHAR_W-1:0] CASE_OFFSET = 16'd32;

  // live vector right after re-arm: only position zero
  localparam logic [MASK_MAX:0] LIVE_ARM = (MASK_MAX + 1)'(1);

  // input word command codes
  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_NAME   = 2'd2,
    CMD_END    = 2'd3
  } cmd_e;

  // operations the controller issues to the datapath
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_CLEAR,
    OP_APPEND,
    OP_NAME,
    OP_CLOSE,
    OP_REPORT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  // ascii lower case folds onto upper case when enabled
  function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c, input logic en);
    logic [CHAR_W-1:0] r;
    r = c;
    if (en && c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      r = c - CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

[sv/gwm_ctrl.sv]
// controller state machine: decodes input words and sequences the end-of-name report
module gwm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic [1:0]        command_i,
  output logic              busy,
  output gwm_pkg::dp_cmd_t  dp_cmd_o,
  output logic              result_valid_o
);
  import gwm_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_REPORT
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;
  logic   result_valid_q;
  logic   accept;

  assign accept = start && !busy_q;

  // command decode
  always_comb begin
    dp_cmd_o.op = OP_IDLE;
    state_d     = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_e'(command_i))
            CMD_CLEAR:  dp_cmd_o.op = OP_CLEAR;
            CMD_APPEND: dp_cmd_o.op = OP_APPEND;
            CMD_NAME:   dp_cmd_o.op = OP_NAME;
            CMD_END: begin
              dp_cmd_o.op = OP_CLOSE;
              state_d     = ST_REPORT;
            end
            default:    dp_cmd_o.op = OP_IDLE;
          endcase
        end
      end
      ST_REPORT: begin
        dp_cmd_o.op = OP_REPORT;
        state_d     = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      busy_q         <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      busy_q         <= (state_d == ST_REPORT);
      result_valid_q <= (state_q == ST_REPORT);
    end
  end

  assign busy           = busy_q;
  assign result_valid_o = result_valid_q;

`ifndef NO_ASSERTIONS
  a_report_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |=> !busy_q) else $error("report state held more than one cycle");
  a_end_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && command_i == CMD_END) |=> busy_q) else $error("end of name did not start report");
  a_strobe_after_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy_q)) else $error("result strobe without report cycle");
`endif

endmodule

[sv/gwm_datapath.sv]
// datapath: mask lanes, live position vector, star closure and result registers
module gwm_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  gwm_pkg::dp_cmd_t             dp_cmd_i,
  input  logic [gwm_pkg::CHAR_W-1:0]   character_i,
  input  logic                         cfg_we_i,
  input  logic                         cfg_wdata_i,
  output logic                         matched_o,
  output logic                         mask_overflow_o
);
  import gwm_pkg::*;

  logic [CHAR_W-1:0] mask_q [MASK_MAX];
  logic [LEN_W-1:0]  len_q, len_d;
  logic [MASK_MAX:0] live_q, live_d;
  logic              ovf_q, ovf_d;
  logic              case_fold_q;
  logic              matched_q;
  logic              ovf_out_q;
  logic              full;

  logic [MASK_MAX-1:0] act;
  logic [MASK_MAX-1:0] star;
  logic [MASK_MAX-1:0] hit;
  logic [MASK_MAX:0]   add_a, add_b, add_sum, carry;
  logic [MASK_MAX:0]   closed;
  logic [MASK_MAX-1:0] stay, adv;
  logic [CHAR_W-1:0]   name_fold;

  assign full      = (len_q == LEN_W'(MASK_MAX));
  assign name_fold = fold(character_i, case_fold_q);

  // per-lane decode of stored mask characters
  always_comb begin
    for (int i = 0; i < MASK_MAX; i++) begin
      act[i]  = (len_q > LEN_W'(i));
      star[i] = act[i] && (mask_q[i] == CH_STAR);
      hit[i]  = act[i] && !star[i]
                && ((mask_q[i] == CH_QMARK) || (fold(mask_q[i], case_fold_q) == name_fold));
    end
  end

  // star closure as a carry chain: carry into j+1 = star[j] & (live[j] | carry[j])
  assign add_a   = {1'b0, star};
  assign add_b   = {1'b0, star & live_q[MASK_MAX-1:0]};
  assign add_sum = add_a + add_b;
  assign carry   = add_sum ^ add_a ^ add_b;
  assign closed  = live_q | carry;

  // one name character step
  assign stay = closed[MASK_MAX-1:0] & star;
  assign adv  = closed[MASK_MAX-1:0] & hit;

  // next state of the control registers
  always_comb begin
    len_d  = len_q;
    live_d = live_q;
    ovf_d  = ovf_q;
    case (dp_cmd_i.op)
      OP_CLEAR: begin
        len_d  = '0;
        ovf_d  = 1'b0;
        live_d = LIVE_ARM;
      end
      OP_APPEND: begin
        if (full) begin
          ovf_d = 1'b1;
        end else begin
          len_d = len_q + LEN_W'(1);
        end
        live_d = LIVE_ARM;
      end
      OP_NAME:   live_d = {1'b0, stay} | {adv, 1'b0};
      OP_CLOSE:  live_d = closed;
      OP_REPORT: live_d = LIVE_ARM;
      default:   live_d = live_q;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      live_q      <= LIVE_ARM;
      ovf_q       <= 1'b0;
      case_fold_q <= 1'b0;
    end else begin
      len_q  <= len_d;
      live_q <= live_d;
      ovf_q  <= ovf_d;
      if (cfg_we_i) begin
        case_fold_q <= cfg_wdata_i;
      end
    end
  end

  // mask lanes, written one at a time
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.op == OP_APPEND && !full) begin
      mask_q[len_q[IDX_W-1:0]] <= character_i;
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.op == OP_REPORT) begin
      matched_q <= live_q[len_q];
      ovf_out_q <= ovf_q;
    end
  end

  assign matched_o       = matched_q;
  assign mask_overflow_o = ovf_out_q;

`ifndef NO_ASSERTIONS
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(MASK_MAX)) else $error("mask length beyond store");
  a_ovf_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> full) else $error("overflow flag set with room in store");
  a_live_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((live_q >> len_q) >> 1) == '0) else $error("live position beyond mask length");
`endif

endmodule

[sv/glob_wildcard_matcher_unit.sv]
// glob wildcard matcher: mask load, name streaming and end-of-name match report
// mask and name words are taken whenever busy is low; the next word may start in the following cycle
// end of name runs a closure step, then a report step, with busy high during the report step
// the result strobe is registered from the report state and is high for one cycle
// the receiver cannot stall; reset clears length, overflow and case fold, and re-arms the match
module glob_wildcard_matcher_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  command_i,
  input  logic [gwm_pkg::CHAR_W-1:0]  character_i,
  input  logic                        cfg_we_i,
  input  logic                        cfg_wdata_i,
  output logic                        result_valid_o,
  output logic                        matched_o,
  output logic                        mask_overflow_o
);
  import gwm_pkg::*;

  dp_cmd_t dp_cmd;

  // controller
  gwm_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .command_i      (command_i),
    .busy           (busy),
    .dp_cmd_o       (dp_cmd),
    .result_valid_o (result_valid_o)
  );

  // datapath
  gwm_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .dp_cmd_i        (dp_cmd),
    .character_i     (character_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .matched_o       (matched_o),
    .mask_overflow_o (mask_overflow_o)
  );

endmodule

[dv/glob_wildcard_matcher_unit_tb.sv]
// self-checking testbench for the glob wildcard matcher unit
`timescale 1ns / 100ps

module glob_wildcard_matcher_unit_tb;
  import gwm_pkg::*;

  localparam int unsigned CLK_HALF_NS   = 4;
  localparam int unsigned TIMEOUT_NS    = 2_000_000;
  localparam int unsigned PHASE_WORDS   = 650;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned MAX_SHOWN     = 10;

  // one end-of-name verdict as the unit reports it
  typedef struct packed {
    logic matched;
    logic overflow;
  } match_verdict_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              start       = 1'b0;
  logic              busy;
  logic [1:0]        command_i   = CMD_CLEAR;
  logic [CHAR_W-1:0] character_i = '0;
  logic              cfg_we_i    = 1'b0;
  logic              cfg_wdata_i = 1'b0;
  logic              result_valid_o;
  logic              matched_o;
  logic              mask_overflow_o;

  // shadow copy of the matcher state
  logic [CHAR_W-1:0] glob_mask [MASK_MAX];
  int unsigned       glob_len;
  logic [MASK_MAX:0] live_set;
  logic              dropped_chars;
  logic              fold_enable;

  match_verdict_t    pending_verdicts [$];
  match_verdict_t    oldest_verdict;
  int unsigned       mismatch_count;
  int unsigned       words_sent;
  int unsigned       burst_left;

  glob_wildcard_matcher_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .command_i       (command_i),
    .character_i     (character_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .result_valid_o  (result_valid_o),
    .matched_o       (matched_o),
    .mask_overflow_o (mask_overflow_o)
  );

  // clock
  initial begin
    forever #(CLK_HALF_NS) clk_i = ~clk_i;
  end

  // hard stop for a hung run
  initial begin
    #(TIMEOUT_NS);
    $display("TEST FAILED");
    $finish;
  end

  // upper-cases ascii letters when folding is on
  function automatic logic [CHAR_W-1:0] upper_if_folding(input logic [CHAR_W-1:0] c);
    if (fold_enable && (c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) begin
      return c - CASE_OFFSET;
    end
    return c;
  endfunction

  // a live position before a star also lives past it
  function automatic void spread_over_stars();
    for (int i = 0; i < glob_len; i++) begin
      if (live_set[i] && glob_mask[i] == CH_STAR) begin
        live_set[i+1] = 1'b1;
      end
    end
  endfunction

  function automatic void rearm_live_set();
    live_set = LIVE_ARM;
  endfunction

  // advance the live set by one name character
  function automatic void consume_name_char(input logic [CHAR_W-1:0] c);
    logic [MASK_MAX:0] nxt;
    nxt = '0;
    spread_over_stars();
    for (int i = 0; i < glob_len; i++) begin
      if (live_set[i]) begin
        if (glob_mask[i] == CH_STAR) begin
          nxt[i] = 1'b1;
        end else if (glob_mask[i] == CH_QMARK ||
                     upper_if_folding(glob_mask[i]) == upper_if_folding(c)) begin
          nxt[i+1] = 1'b1;
        end
      end
    end
    live_set = nxt;
  endfunction

  // predicted effect of one accepted word
  function automatic void predict_glob_word(input cmd_e cmd, input logic [CHAR_W-1:0] c);
    match_verdict_t v;
    case (cmd)
      CMD_CLEAR: begin
        glob_len      = 0;
        dropped_chars = 1'b0;
        rearm_live_set();
      end
      CMD_APPEND: begin
        if (glob_len < MASK_MAX) begin
          glob_mask[glob_len] = c;
          glob_len++;
        end else begin
          dropped_chars = 1'b1;
        end
        rearm_live_set();
      end
      CMD_NAME: begin
        consume_name_char(c);
      end
      default: begin
        spread_over_stars();
        v.matched  = live_set[glob_len];
        v.overflow = dropped_chars;
        pending_verdicts.push_back(v);
        rearm_live_set();
      end
    endcase
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (pending_verdicts.size() == 0) begin
        if (mismatch_count < MAX_SHOWN) begin
          $display("unexpected result: matched=%b overflow=%b", matched_o, mask_overflow_o);
        end
        mismatch_count++;
      end else begin
        oldest_verdict = pending_verdicts.pop_front();
        if (matched_o !== oldest_verdict.matched ||
            mask_overflow_o !== oldest_verdict.overflow) begin
          if (mismatch_count < MAX_SHOWN) begin
            $display("result mismatch: matched exp %b got %b, overflow exp %b got %b",
                     oldest_verdict.matched, matched_o, oldest_verdict.overflow,
                     mask_overflow_o);
          end
          mismatch_count++;
        end
      end
    end
  end

  // sender drops start and stays quiet
  task automatic hold_sender(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // present one word and wait until the unit takes it
  task automatic send_word(input cmd_e cmd, input logic [CHAR_W-1:0] c);
    if (burst_left == 0) begin
      hold_sender($urandom_range(1, 6));
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 160)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    start       <= 1'b1;
    command_i   <= cmd;
    character_i <= c;
    do begin
      @(posedge clk_i);
    end while (busy);
    words_sent++;
    predict_glob_word(cmd, c);
  endtask

  // wait for every expected verdict, then let the pipeline settle
  task automatic drain_results();
    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_case_fold(input logic value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    fold_enable = value;
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [CHAR_W-1:0] swap_case(input logic [CHAR_W-1:0] c);
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      return c - CASE_OFFSET;
    end
    if (c >= CH_LOWER_A - CASE_OFFSET && c <= CH_LOWER_Z - CASE_OFFSET) begin
      return c + CASE_OFFSET;
    end
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] random_letter();
    logic [CHAR_W-1:0] c;
    c = CH_LOWER_A + 16'($urandom_range(0, 3));
    return ($urandom_range(0, 1) == 0) ? c : swap_case(c);
  endfunction

  // mask alphabet biased toward wildcards and a few letters
  function automatic logic [CHAR_W-1:0] random_mask_char();
    case ($urandom_range(0, 15))
      0, 1, 2, 3: return CH_STAR;
      4, 5, 6:    return CH_QMARK;
      13:         return '0;
      14:         return '1;
      15:         return 16'($urandom);
      default:    return random_letter();
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] random_name_char();
    case ($urandom_range(0, 9))
      6:       return CH_STAR;
      7:       return CH_QMARK;
      8:       return '0;
      9:       return 16'($urandom);
      default: return random_letter();
    endcase
  endfunction

  // load a mask, then stream names built mostly to fit it
  task automatic send_glob_case();
    logic [CHAR_W-1:0] pat [$];
    logic [CHAR_W-1:0] nm [$];
    int unsigned       mlen;
    int unsigned       nnames;
    if ($urandom_range(0, 7) != 0) begin
      send_word(CMD_CLEAR, 16'($urandom));
    end
    mlen = ($urandom_range(0, 14) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 8);
    for (int i = 0; i < mlen; i++) begin
      pat.push_back(random_mask_char());
      send_word(CMD_APPEND, pat[i]);
    end
    nnames = $urandom_range(1, 4);
    repeat (nnames) begin
      nm.delete();
      foreach (pat[i]) begin
        if (pat[i] == CH_STAR) begin
          repeat ($urandom_range(0, 3)) nm.push_back(random_name_char());
        end else if (pat[i] == CH_QMARK) begin
          nm.push_back(random_name_char());
        end else begin
          nm.push_back(($urandom_range(0, 3) == 0) ? swap_case(pat[i]) : pat[i]);
        end
      end
      // occasional broken name
      case ($urandom_range(0, 7))
        0: begin
          if (nm.size() > 0) nm[$urandom_range(0, nm.size() - 1)] = random_name_char();
        end
        1: begin
          if (nm.size() > 0) void'(nm.pop_back());
        end
        2: nm.push_back(random_name_char());
        default: ;
      endcase
      foreach (nm[i]) send_word(CMD_NAME, nm[i]);
      send_word(CMD_END, 16'($urandom));
    end
  endtask

  // arbitrary command with arbitrary character
  task automatic send_noise_word();
    cmd_e cmd;
    cmd = cmd_e'($urandom_range(0, 3));
    send_word(cmd, ($urandom_range(0, 1) == 0) ? 16'($urandom) : random_letter());
  endtask

  task automatic test_reset_state();
    send_word(CMD_END, '0);
    send_word(CMD_APPEND, "a");
    send_word(CMD_NAME, "A");
    send_word(CMD_END, '1);
  endtask

  task automatic test_wildcards();
    send_word(CMD_CLEAR, '1);
    send_word(CMD_APPEND, "a");
    send_word(CMD_APPEND, CH_STAR);
    send_word(CMD_APPEND, CH_QMARK);
    send_word(CMD_APPEND, "C");
    send_word(CMD_NAME, "a");
    send_word(CMD_NAME, "b");
    send_word(CMD_NAME, "x");
    send_word(CMD_NAME, "C");
    send_word(CMD_END, '0);
    send_word(CMD_NAME, "a");
    send_word(CMD_NAME, "C");
    send_word(CMD_END, '0);
  endtask

  task automatic test_empty_name_and_extremes();
    send_word(CMD_CLEAR, '0);
    send_word(CMD_APPEND, CH_STAR);
    send_word(CMD_APPEND, CH_STAR);
    send_word(CMD_END, '0);
    send_word(CMD_NAME, '0);
    send_word(CMD_NAME, '1);
    send_word(CMD_END, '0);
    // code zero is an ordinary character
    send_word(CMD_CLEAR, '0);
    send_word(CMD_APPEND, '0);
    send_word(CMD_APPEND, '1);
    send_word(CMD_NAME, '0);
    send_word(CMD_NAME, '1);
    send_word(CMD_END, '0);
    send_word(CMD_END, '0);
  endtask

  task automatic test_literal_star_in_name();
    send_word(CMD_CLEAR, '0);
    send_word(CMD_APPEND, "a");
    send_word(CMD_APPEND, CH_QMARK);
    send_word(CMD_NAME, "a");
    send_word(CMD_NAME, CH_STAR);
    send_word(CMD_END, '0);
  endtask

  task automatic test_mask_change_mid_name();
    send_word(CMD_CLEAR, '0);
    send_word(CMD_APPEND, "x");
    send_word(CMD_NAME, "x");
    send_word(CMD_APPEND, "y");
    send_word(CMD_NAME, "x");
    send_word(CMD_NAME, "y");
    send_word(CMD_END, '0);
    send_word(CMD_NAME, "q");
    send_word(CMD_CLEAR, '0);
    send_word(CMD_END, '0);
  endtask

  task automatic test_case_fold();
    write_case_fold(1'b1);
    send_word(CMD_CLEAR, '0);
    send_word(CMD_APPEND, "a");
    send_word(CMD_APPEND, "Z");
    send_word(CMD_APPEND, "{");
    send_word(CMD_NAME, "A");
    send_word(CMD_NAME, "z");
    send_word(CMD_NAME, "[");
    send_word(CMD_END, '0);
    // folding switched off between two name characters
    send_word(CMD_CLEAR, '0);
    send_word(CMD_APPEND, "b");
    send_word(CMD_APPEND, "b");
    send_word(CMD_NAME, "B");
    write_case_fold(1'b0);
    send_word(CMD_NAME, "B");
    send_word(CMD_END, '0);
  endtask

  task automatic test_mask_overflow();
    send_word(CMD_CLEAR, '0);
    repeat (MASK_MAX + 1) send_word(CMD_APPEND, CH_STAR);
    send_word(CMD_NAME, "q");
    send_word(CMD_END, '0);
    send_word(CMD_CLEAR, '0);
    send_word(CMD_END, '0);
  endtask

  task automatic test_random_phase(input logic fold_value, input int unsigned n_words);
    int unsigned target;
    write_case_fold(fold_value);
    target = words_sent + n_words;
    while (words_sent < target) begin
      if ($urandom_range(0, 9) < 8) begin
        send_glob_case();
      end else begin
        send_noise_word();
      end
    end
  endtask

  // main sequence
  initial begin
    mismatch_count = 0;
    words_sent     = 0;
    burst_left     = $urandom_range(1, 12);
    glob_len       = 0;
    dropped_chars  = 1'b0;
    fold_enable    = 1'b0;
    live_set       = LIVE_ARM;
    foreach (glob_mask[i]) glob_mask[i] = '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_reset_state();
    test_wildcards();
    test_empty_name_and_extremes();
    test_literal_star_in_name();
    test_mask_change_mid_name();
    test_case_fold();
    test_mask_overflow();
    test_random_phase(1'b0, PHASE_WORDS);
    test_random_phase(1'b1, PHASE_WORDS);
    test_random_phase(1'b0, PHASE_WORDS);

    drain_results();
    if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
sv/gwm_pkg.sv
sv/gwm_ctrl.sv
sv/gwm_datapath.sv
sv/glob_wildcard_matcher_unit.sv
dv/glob_wildcard_matcher_unit_tb.sv
